[rtl/core/gcr62_pkg.sv]
// Shared types and constants of the GCR 6-and-2 sector data encoder.
// Holds the sector geometry, the job record passed front to back and the code table.
// No dependencies.
package gcr62_pkg;

   localparam int TagBytes    = 12;
   localparam int SectorBytes = TagBytes + 512;
   localparam int PosWidth    = 10;
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(SectorBytes - 1);

   localparam int MaxNibbles = 7;
   localparam int CntWidth   = 3;

   // Place of a byte within its group of three
   typedef enum logic [2:0] {
      ROLE_FIRST  = 3'b001,
      ROLE_SECOND = 3'b010,
      ROLE_THIRD  = 3'b100
   } role_type;

   // One burst of nibbles for the back end, six-bit codes in output order
   typedef struct packed {
      logic [MaxNibbles-1:0][5:0] six;
      logic [CntWidth-1:0]        count;
      logic                       tail;
   } job_type;

   localparam logic [7:0] GcrCode [0:63] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

endpackage

[rtl/core/gcr62_req_if.sv]
// Input channel of the sector data encoder: one sector stream byte per transfer.
// Valid/ready handshake; no dependencies.
interface gcr62_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       sector_start;

   modport source (output valid, output data_byte, output sector_start, input ready);
   modport sink   (input valid, input data_byte, input sector_start, output ready);
endinterface

[rtl/core/gcr62_rsp_if.sv]
// Result channel of the sector data encoder: one GCR disk byte per transfer.
// Valid/ready handshake; no dependencies.
interface gcr62_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] disk_byte;
   logic       field_end;

   modport source (output valid, output disk_byte, output field_end, input ready);
   modport sink   (input valid, input disk_byte, input field_end, output ready);
endinterface

[rtl/core/gcr62_front.sv]
// Front end: takes sector bytes, runs the rolling checksums and scrambler,
// and builds nibble jobs for the queue. Depends on gcr62_pkg and gcr62_req_if.
module gcr62_front (
   input  logic              clock,
   input  logic              reset,
   gcr62_req_if.sink         req_ch,
   input  logic              q_full,
   output logic              push,
   output gcr62_pkg::job_type job
);
   import gcr62_pkg::*;

   logic [8:0]          cs_a_ff, cs_b_ff, cs_c_ff;
   logic [8:0]          cs_a_in, cs_b_in, cs_c_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   role_type            role_ff, role_in;
   logic [7:0]          first_ff, first_in, second_ff, second_in;

   logic                accept, last;
   logic [8:0]          cs_a, cs_b, cs_c, na, nb, nc;
   logic [PosWidth-1:0] pos_cur;
   role_type            role_cur, role_nxt;
   logic [7:0]          byte_v, third;
   logic [5:0]          ck_top;

   always_comb begin
      req_ch.ready = !q_full;
      accept   = req_ch.valid && !q_full;
      byte_v   = req_ch.data_byte;
      cs_a     = req_ch.sector_start ? 9'd0 : cs_a_ff;
      cs_b     = req_ch.sector_start ? 9'd0 : cs_b_ff;
      cs_c     = req_ch.sector_start ? 9'd0 : cs_c_ff;
      pos_cur  = req_ch.sector_start ? '0 : pos_ff;
      role_cur = req_ch.sector_start ? ROLE_FIRST : role_ff;
      last     = (pos_cur == LastPos);

      na        = cs_a;
      nb        = cs_b;
      nc        = cs_c;
      first_in  = first_ff;
      second_in = second_ff;
      third     = 8'd0;
      role_nxt  = ROLE_FIRST;

      unique case (role_cur)
         ROLE_FIRST: begin
            // rotate within 8 bits, carry out feeds checksum_c
            na       = {1'b0, cs_a[6:0], cs_a[7]};
            nc       = cs_c + {1'b0, byte_v} + {8'd0, cs_a[7]};
            first_in = byte_v ^ {cs_a[6:0], cs_a[7]};
            role_nxt = ROLE_SECOND;
         end
         ROLE_SECOND: begin
            nb        = cs_b + {1'b0, byte_v} + {8'd0, cs_c[8]};
            nc        = {1'b0, cs_c[7:0]};
            second_in = byte_v ^ cs_c[7:0];
            role_nxt  = ROLE_THIRD;
         end
         ROLE_THIRD: begin
            na       = cs_a + {1'b0, byte_v} + {8'd0, cs_b[8]};
            nb       = {1'b0, cs_b[7:0]};
            third    = byte_v ^ cs_b[7:0];
            role_nxt = ROLE_FIRST;
         end
         default: role_nxt = ROLE_FIRST;
      endcase

      ck_top = {nc[7:6], nb[7:6], na[7:6]};
      job    = '0;
      if (role_cur == ROLE_THIRD) begin
         job.six[0] = {first_ff[7:6], second_ff[7:6], third[7:6]};
         job.six[1] = first_ff[5:0];
         job.six[2] = second_ff[5:0];
         job.six[3] = third[5:0];
         job.count  = CntWidth'(4);
      end else if (last && role_cur == ROLE_SECOND) begin
         job.six[0] = {first_in[7:6], second_in[7:6], 2'b00};
         job.six[1] = first_in[5:0];
         job.six[2] = second_in[5:0];
         job.six[3] = ck_top;
         job.six[4] = nc[5:0];
         job.six[5] = nb[5:0];
         job.six[6] = na[5:0];
         job.count  = CntWidth'(7);
         job.tail   = 1'b1;
      end else if (last) begin
         job.six[0] = {first_in[7:6], second_in[7:6], 2'b00};
         job.six[1] = first_in[5:0];
         job.six[2] = ck_top;
         job.six[3] = nc[5:0];
         job.six[4] = nb[5:0];
         job.six[5] = na[5:0];
         job.count  = CntWidth'(6);
         job.tail   = 1'b1;
      end
      push = accept && (role_cur == ROLE_THIRD || last);

      // end of sector: drop checksums and position
      cs_a_in = last ? 9'd0 : na;
      cs_b_in = last ? 9'd0 : nb;
      cs_c_in = last ? 9'd0 : nc;
      pos_in  = last ? '0 : pos_cur + PosWidth'(1);
      role_in = last ? ROLE_FIRST : role_nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_a_ff   <= '0;
         cs_b_ff   <= '0;
         cs_c_ff   <= '0;
         pos_ff    <= '0;
         role_ff   <= ROLE_FIRST;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (accept) begin
         cs_a_ff   <= cs_a_in;
         cs_b_ff   <= cs_b_in;
         cs_c_ff   <= cs_c_in;
         pos_ff    <= pos_in;
         role_ff   <= role_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

endmodule

[rtl/core/gcr62_queue.sv]
// Job queue between front and back end of the sector data encoder.
// Small register FIFO of job records; depends on gcr62_pkg.
module gcr62_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gcr62_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output gcr62_pkg::job_type head_job
);
   import gcr62_pkg::*;

   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [AddrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full       = (count_ff == CountW'(DEPTH));
      head_valid = (count_ff != '0);
      head_job   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AddrW'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AddrW'(1);
      if (do_push && !do_pop)
         count_in = count_ff + CountW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - CountW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

[rtl/core/gcr62_back.sv]
// Back end: walks the head job one nibble per unstalled cycle through the GCR
// code table into the output register. Depends on gcr62_pkg and gcr62_rsp_if.
module gcr62_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  gcr62_pkg::job_type head_job,
   output logic               pop,
   gcr62_rsp_if.source        rsp_ch
);
   import gcr62_pkg::*;

   logic [CntWidth-1:0] idx_ff, idx_in;
   logic                vld_ff, vld_in;
   logic [7:0]          disk_ff, disk_in;
   logic                end_ff, end_in;
   logic                load, last_nib;

   always_comb begin
      load     = head_valid && (!vld_ff || rsp_ch.ready);
      last_nib = ((idx_ff + CntWidth'(1)) == head_job.count);
      pop      = load && last_nib;
      disk_in  = GcrCode[head_job.six[idx_ff]];
      end_in   = head_job.tail && last_nib;
      idx_in   = idx_ff;
      if (load)
         idx_in = last_nib ? '0 : idx_ff + CntWidth'(1);
      vld_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : vld_ff);

      rsp_ch.valid     = vld_ff;
      rsp_ch.disk_byte = disk_ff;
      rsp_ch.field_end = end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   // hold payload until the transfer completes
   always_ff @(posedge clock) begin
      if (load) begin
         disk_ff <= disk_in;
         end_ff  <= end_in;
      end
   end

endmodule

[rtl/core/gcr62_sector_data_encoder_top.sv]
// GCR 6-and-2 sector data encoder: 524 bytes in, 703 disk bytes out per sector.
// The first nibble of a group passes through the job queue and the back end's output
// register after its third byte is taken.
// Throughput: one byte in per cycle while the job queue has room, one nibble out
// per cycle from the back end while not stalled; the output port sets the sustained rate.
// Reset (synchronous): clears checksums, position, queue and output valid.
module gcr62_sector_data_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   gcr62_req_if.sink   req_ch,
   gcr62_rsp_if.source rsp_ch
);
   import gcr62_pkg::*;

   logic    push, q_full, head_valid, pop;
   job_type push_job, head_job;

   gcr62_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push),
      .job    (push_job)
   );

   gcr62_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   gcr62_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
